// ===== src/note_timing_quantizer_buffer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the note timing quantizer buffer unit
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef NOTE_TIMING_QUANTIZER_BUFFER_UNIT_ASSERT_SVH
`define NOTE_TIMING_QUANTIZER_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NTQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define NTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ntq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntq_pkg
// Types, codes and constants shared by the note timing quantizer files.
// ----------------------------------------------------------------------------
package ntq_pkg;

    // Action codes of an input transaction.
    localparam logic [1:0] ACT_NOTE_ON = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    // Snap modes.
    localparam logic [1:0] SNAP_NEXT = 2'd1;
    localparam logic [1:0] SNAP_PREV = 2'd2;

    // Register indexes (byte address is eight times the index).
    localparam logic [2:0] REG_TEMPO    = 3'd0;
    localparam logic [2:0] REG_ENABLE   = 3'd1;
    localparam logic [2:0] REG_RES      = 3'd2;
    localparam logic [2:0] REG_STRENGTH = 3'd3;
    localparam logic [2:0] REG_SNAP     = 3'd4;
    localparam logic [2:0] REG_SWING    = 3'd5;

    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // Arithmetic constants.
    localparam logic [15:0] MS_PER_MINUTE  = 16'd60000;
    localparam logic [15:0] DEFAULT_BEAT   = 16'd500;
    localparam logic [6:0]  PCT_FULL       = 7'd100;
    localparam logic [6:0]  SWING_STRAIGHT = 7'd50;

    // Divider widths: dividend covers the arrival time, divisor the grid.
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 16;

    // Division by one hundred as a multiply by ceil(2^32 / 100) and a shift.
    // Exact for every dividend below 2^30.
    localparam logic [25:0] RECIP_100   = 26'd42949673;
    localparam int          RECIP_SHIFT = 32;

    // Reset values of the registers.
    localparam logic [8:0]  RST_TEMPO    = 9'd120;
    localparam logic [7:0]  RST_ENABLE   = 8'd0;
    localparam logic [23:0] RST_RES      = 24'd7190235;
    localparam logic [55:0] RST_STRENGTH = 56'd56738263021990500;
    localparam logic [15:0] RST_SNAP     = 16'd0;
    localparam logic [55:0] RST_SWING    = 56'd28369131510995250;

    typedef struct packed {
        logic [8:0]  tempo_bpm;
        logic [7:0]  track_enable_mask;
        logic [23:0] resolution_table;
        logic [55:0] strength_table;
        logic [15:0] snap_mode_table;
        logic [55:0] swing_table;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  track;
        logic [6:0]  note_number;
        logic [6:0]  note_velocity;
        logic [3:0]  midi_channel;
        logic [31:0] time_value;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        note_valid;
        logic [6:0]  out_note;
        logic [6:0]  out_velocity;
        logic [3:0]  out_channel;
        logic [31:0] out_original_time;
        logic [31:0] out_quantized_time;
        logic        last;
    } t_out_item;

    // One stored note.
    typedef struct packed {
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [3:0]  channel;
        logic [31:0] orig_time;
        logic [31:0] quant_time;
    } t_slot_rec;

    // Grid divisor for a resolution code.
    function automatic logic [4:0] grid_divisor(input logic [2:0] code);
        logic [4:0] d;
        begin
            case (code)
                3'd0:    d = 5'd1;
                3'd1:    d = 5'd2;
                3'd2:    d = 5'd3;
                3'd3:    d = 5'd4;
                3'd4:    d = 5'd6;
                3'd5:    d = 5'd8;
                3'd6:    d = 5'd12;
                default: d = 5'd16;
            endcase
            return d;
        end
    endfunction

    // Percent field clamped to one hundred.
    function automatic logic [6:0] clamp_pct(input logic [6:0] v);
        begin
            return (v > PCT_FULL) ? PCT_FULL : v;
        end
    endfunction

endpackage

// ===== src/ntq_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntq_in_if
// Input channel: one note event or command per transaction.
// ----------------------------------------------------------------------------
interface ntq_in_if import ntq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ntq_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntq_out_if
// Output channel: one or more results per transaction, the last one flagged.
// ----------------------------------------------------------------------------
interface ntq_out_if import ntq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/note_timing_quantizer_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_timing_quantizer_buffer_unit
// Per-track note buffer that quantizes note-on times to a swung grid and
// releases stored notes once their quantized time is reached.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Carries
//  i_in      in         valid / ready        action, track, note, time
//  o_out     out        valid / ready        results, last one flagged
//  APB       in / out   psel, penable, ...   six configuration registers
//
//  Note-on: three divisions (beat, grid, grid index) on a shared bit-serial
//  divider, then swing and strength, where they apply, by reciprocal
//  multiply; with zero strength or grid the result is written after the grid
//  division, and a rejected note-on goes straight to the flush. Release: each
//  slot of the track is read and checked in turn, then the flush. Clear and
//  other actions go straight to the flush. One transaction is worked at a
//  time. Reset is synchronous; slot valid bits clear at once, no clearing pass.
//  A stalled output holds its result; work waits only when it must emit.
// ----------------------------------------------------------------------------
module note_timing_quantizer_buffer_unit import ntq_pkg::*; #(
    parameter int TRACKS          = 8,
    parameter int SLOTS_PER_TRACK = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ntq_in_if.sink             i_in,
    ntq_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int NSLOT = TRACKS * SLOTS_PER_TRACK;
    localparam int AW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int IW    = (SLOTS_PER_TRACK > 1) ? $clog2(SLOTS_PER_TRACK) : 1;
    localparam logic [AW-1:0] SLOTS_A  = AW'(SLOTS_PER_TRACK);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS_PER_TRACK - 1);

    // Controller states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_DIVW  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_CHK   = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    // Division phases of a note-on.
    localparam logic [2:0] PH_BEAT  = 3'd0;
    localparam logic [2:0] PH_GRID  = 3'd1;
    localparam logic [2:0] PH_N     = 3'd2;
    localparam logic [2:0] PH_SWING = 3'd3;
    localparam logic [2:0] PH_STR   = 3'd4;

    t_cfg cfg;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_trk;
    logic [6:0]  r_note, r_vel;
    logic [3:0]  r_ch;
    logic [31:0] r_time;
    logic [IW-1:0] r_idx, n_idx;
    logic [15:0] r_g, n_g;
    logic signed [34:0] r_p, n_p;
    logic        r_neg, n_neg;
    logic [31:0] r_q, n_q;
    logic        r_pend, n_pend;
    t_out_item   r_res, n_res;
    t_out_item   r_out, n_out;
    logic        r_out_vld, n_out_vld;
    logic [SLOTS_PER_TRACK-1:0] r_active [TRACKS];

    // Per-track settings of the latched track.
    logic [6:0]  trk_sw, trk_str;
    logic [1:0]  trk_mode;
    logic [4:0]  trk_div;
    logic [5:0]  sw_mag;

    assign trk_sw   = clamp_pct(cfg.swing_table[7*r_trk +: 7]);
    assign trk_str  = clamp_pct(cfg.strength_table[7*r_trk +: 7]);
    assign trk_mode = cfg.snap_mode_table[2*r_trk +: 2];
    assign trk_div  = grid_divisor(cfg.resolution_table[3*r_trk +: 3]);
    assign sw_mag   = (trk_sw >= SWING_STRAIGHT) ? 6'(trk_sw - SWING_STRAIGHT)
                                                 : 6'(SWING_STRAIGHT - trk_sw);

    ntq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Shared divider.
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_n, div_quo;
    logic [DIV_DW-1:0] div_d, div_rem;

    ntq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_quo),
        .o_rem      (div_rem)
    );

    // Slot memory.
    logic [AW-1:0] addr;
    logic          mem_we, mem_re;
    t_slot_rec     wrec, rrec;

    assign addr = AW'(r_trk) * SLOTS_A + AW'(r_idx);
    assign wrec = '{note: r_note, velocity: r_vel, channel: r_ch,
                    orig_time: r_time, quant_time: r_q};

    ntq_slot_mem #(.DEPTH(NSLOT), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (addr),
        .i_wdata (wrec),
        .i_re    (mem_re),
        .i_raddr (addr),
        .o_rdata (rrec)
    );

    // Lowest free slot of the incoming transaction's track.
    logic [SLOTS_PER_TRACK-1:0] in_word;
    logic [IW-1:0] free_idx;
    logic          free_any;
    logic          in_trk_ok;

    assign in_word   = r_active[i_in.payload.track];
    assign in_trk_ok = ({29'd0, i_in.payload.track} < 32'(TRACKS));

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = SLOTS_PER_TRACK - 1; i >= 0; i--) begin
            if (!in_word[i]) begin
                free_idx = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    // Signed work for the strength step.
    logic signed [34:0] delta;
    logic [33:0]        delta_mag;
    logic [40:0]        str_prod;
    logic [21:0]        sw_prod;
    logic [15:0]        rem_g;
    logic               snap_up;
    logic signed [41:0] q_wide;

    // Division by one hundred for swing and strength.
    logic        ph_const, rc_start, rc_done, step_done;
    logic [29:0] rc_dvd;
    logic [29:0] r_rc_x;
    logic [55:0] rc_prod;
    logic [23:0] r_rc_q;
    logic [1:0]  r_rc_v;

    assign delta     = r_p - $signed({3'b0, r_time});
    assign delta_mag = delta[34] ? 34'(-delta) : delta[33:0];
    assign str_prod  = 41'(delta_mag) * 41'(trk_str);
    assign sw_prod   = 22'(sw_mag) * 22'(r_g);
    assign rem_g     = div_rem[15:0];
    assign q_wide    = $signed({10'b0, r_time})
                     + (r_neg ? -$signed({18'b0, r_rc_q}) : $signed({18'b0, r_rc_q}));

    assign ph_const  = (r_phase == PH_SWING) || (r_phase == PH_STR);
    assign rc_start  = (r_state == S_DIV) && ph_const;
    assign rc_dvd    = (r_phase == PH_SWING) ? 30'(sw_prod) : 30'(str_prod);
    assign rc_prod   = 56'(r_rc_x) * 56'(RECIP_100);
    assign rc_done   = r_rc_v[1];
    assign step_done = ph_const ? rc_done : div_done;

    // Reciprocal pipeline: operand register, then product register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc_v <= '0;
        end else begin
            r_rc_v <= {r_rc_v[0], rc_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rc_start) begin
            r_rc_x <= rc_dvd;
        end
        r_rc_q <= rc_prod[RECIP_SHIFT +: 24];
    end

    always_comb begin
        unique case (trk_mode)
            SNAP_NEXT: snap_up = 1'b1;
            SNAP_PREV: snap_up = 1'b0;
            default:   snap_up = (rem_g >= (r_g - rem_g));
        endcase
    end

    // Divider operands per phase.
    always_comb begin
        div_n = '0;
        div_d = 16'd1;
        unique case (r_phase)
            PH_BEAT: begin
                if (cfg.tempo_bpm == '0) begin
                    div_n = DIV_NW'(DEFAULT_BEAT);
                end else begin
                    div_n = DIV_NW'(MS_PER_MINUTE);
                    div_d = 16'(cfg.tempo_bpm);
                end
            end
            PH_GRID: begin
                div_n = DIV_NW'(r_g);
                div_d = 16'(trk_div);
            end
            PH_N: begin
                div_n = DIV_NW'(r_time);
                div_d = r_g;
            end
            default: begin
                div_n = '0;
                div_d = 16'd1;
            end
        endcase
    end

    assign div_start = (r_state == S_DIV) && !ph_const;
    assign mem_we    = (r_state == S_WRITE);
    assign mem_re    = (r_state == S_RD);

    logic out_free;
    logic rel_hit;

    assign out_free = !r_out_vld || o_out.ready;
    assign rel_hit  = r_active[r_trk][r_idx] && (rrec.quant_time <= r_time);

    // Controller.
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_g       = r_g;
        n_p       = r_p;
        n_neg     = r_neg;
        n_q       = r_q;
        n_pend    = r_pend;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_res  = '0;
                    n_pend = 1'b0;
                    n_idx  = '0;
                    n_phase = PH_BEAT;
                    n_state = S_FLUSH;
                    if (i_in.payload.action == ACT_NOTE_ON) begin
                        if (in_trk_ok && free_any
                                && cfg.track_enable_mask[i_in.payload.track]) begin
                            n_idx   = free_idx;
                            n_state = S_DIV;
                        end
                    end else if (i_in.payload.action == ACT_RELEASE) begin
                        if (in_trk_ok) begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_DIV: begin
                if (r_phase == PH_STR) begin
                    n_neg = delta[34];
                end
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (step_done) begin
                    n_state = S_DIV;
                    unique case (r_phase)
                        PH_BEAT: begin
                            n_g     = div_quo[15:0];
                            n_phase = PH_GRID;
                        end
                        PH_GRID: begin
                            n_g = div_quo[15:0];
                            if (div_quo[15:0] == '0 || trk_str == '0) begin
                                n_q     = r_time;
                                n_state = S_WRITE;
                            end else begin
                                n_phase = PH_N;
                            end
                        end
                        PH_N: begin
                            n_p = $signed({3'b0, r_time}) - $signed({19'b0, rem_g})
                                + (snap_up ? $signed({19'b0, r_g}) : 35'sd0);
                            n_neg = (trk_sw < SWING_STRAIGHT);
                            if ((div_quo[0] ^ snap_up) && trk_sw != SWING_STRAIGHT) begin
                                n_phase = PH_SWING;
                            end else begin
                                n_phase = PH_STR;
                            end
                        end
                        PH_SWING: begin
                            n_p = r_neg ? r_p - $signed({11'b0, r_rc_q})
                                        : r_p + $signed({11'b0, r_rc_q});
                            n_phase = PH_STR;
                        end
                        default: begin
                            if (q_wide < 0) begin
                                n_q = '0;
                            end else if (q_wide > 42'sh0FFFFFFFF) begin
                                n_q = '1;
                            end else begin
                                n_q = q_wide[31:0];
                            end
                            n_state = S_WRITE;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                n_res.accepted = 1'b1;
                n_state        = S_FLUSH;
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!rel_hit || !r_pend || out_free) begin
                    if (rel_hit) begin
                        if (r_pend) begin
                            n_out     = r_res;
                            n_out_vld = 1'b1;
                        end
                        n_pend = 1'b1;
                        n_res  = '{accepted: 1'b0, note_valid: 1'b1,
                                   out_note: rrec.note, out_velocity: rrec.velocity,
                                   out_channel: rrec.channel,
                                   out_original_time: rrec.orig_time,
                                   out_quantized_time: rrec.quant_time, last: 1'b0};
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out      = r_res;
                    n_out.last = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_pend    <= n_pend;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_idx   <= n_idx;
        r_g     <= n_g;
        r_p     <= n_p;
        r_neg   <= n_neg;
        r_q     <= n_q;
        r_res   <= n_res;
        r_out   <= n_out;
        if (r_state == S_IDLE && i_in.valid) begin
            r_trk  <= i_in.payload.track;
            r_note <= i_in.payload.note_number;
            r_vel  <= i_in.payload.note_velocity;
            r_ch   <= i_in.payload.midi_channel;
            r_time <= i_in.payload.time_value;
        end
    end

    // Slot valid bits, one word per track.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TRACKS; k++) begin
                r_active[k] <= '0;
            end
        end else begin
            if (r_state == S_WRITE) begin
                r_active[r_trk][r_idx] <= 1'b1;
            end
            if (r_state == S_CHK && n_state != S_CHK && rel_hit) begin
                r_active[r_trk][r_idx] <= 1'b0;
            end
            if (r_state == S_IDLE && i_in.valid && in_trk_ok
                    && i_in.payload.action == ACT_CLEAR) begin
                r_active[i_in.payload.track] <= '0;
            end
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_vld;
    assign o_out.payload = r_out;

endmodule

// ===== src/ntq_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntq_cfg
// APB register file holding tempo and the per-track tables.
// ----------------------------------------------------------------------------
module ntq_cfg import ntq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];
    assign o_cfg   = r_cfg;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tempo_bpm         <= RST_TEMPO;
            r_cfg.track_enable_mask <= RST_ENABLE;
            r_cfg.resolution_table  <= RST_RES;
            r_cfg.strength_table    <= RST_STRENGTH;
            r_cfg.snap_mode_table   <= RST_SNAP;
            r_cfg.swing_table       <= RST_SWING;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TEMPO:    r_cfg.tempo_bpm         <= pwdata[8:0];
                REG_ENABLE:   r_cfg.track_enable_mask <= pwdata[7:0];
                REG_RES:      r_cfg.resolution_table  <= pwdata[23:0];
                REG_STRENGTH: r_cfg.strength_table    <= pwdata[55:0];
                REG_SNAP:     r_cfg.snap_mode_table   <= pwdata[15:0];
                REG_SWING:    r_cfg.swing_table       <= pwdata[55:0];
                default: ;
            endcase
        end
    end

    // Read data.
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_TEMPO:    prdata = PDATA_W'(r_cfg.tempo_bpm);
            REG_ENABLE:   prdata = PDATA_W'(r_cfg.track_enable_mask);
            REG_RES:      prdata = PDATA_W'(r_cfg.resolution_table);
            REG_STRENGTH: prdata = PDATA_W'(r_cfg.strength_table);
            REG_SNAP:     prdata = PDATA_W'(r_cfg.snap_mode_table);
            REG_SWING:    prdata = PDATA_W'(r_cfg.swing_table);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== src/ntq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntq_div import ntq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot,
    output logic [DIV_DW-1:0] o_rem
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;
    logic [CW-1:0]     r_cnt;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              bit_q;

    // One restoring step.
    assign trial = {r_rem, r_quo[DIV_NW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign bit_q = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DIV_NW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_NW-2:0], bit_q};
            r_rem <= bit_q ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== src/ntq_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntq_slot_mem
// Slot record store: one write and one registered read port.
// ----------------------------------------------------------------------------
module ntq_slot_mem import ntq_pkg::*; #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_slot_rec     i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_slot_rec     o_rdata
);

    t_slot_rec mem [DEPTH];
    t_slot_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ntq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntq_checker
// Port-level checks of the note timing quantizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "note_timing_quantizer_buffer_unit_assert.svh"

module ntq_checker import ntq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_payload
);

    // A stalled result holds.
    `NTQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload), "stalled result changed")

    // One transaction is worked at a time.
    `NTQ_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input accepted while busy")

    // An accepted note-on result is a single final result without a note.
    `NTQ_ASSERT_IMPL(a_acc_last, i_clk, i_rst_n, i_out_valid && i_out_payload.accepted, i_out_payload.last && !i_out_payload.note_valid, "accepted result malformed")

    // Only released notes are followed by more results.
    `NTQ_ASSERT_IMPL(a_mid_note, i_clk, i_rst_n, i_out_valid && !i_out_payload.last, i_out_payload.note_valid, "non-final result carries no note")

endmodule

bind note_timing_quantizer_buffer_unit ntq_checker u_ntq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
